>>> rtl/core/pgi_pkg.sv
// ----------------------------------------------------------------------------
// pgi_pkg
// Shared types, register indexes and helper functions for the palette
// gradient interpolator pipeline.
// ----------------------------------------------------------------------------
package pgi_pkg;

	// Configuration register indexes
	localparam logic [0:0] REG_MODE      = 1'b0;
	localparam logic [0:0] REG_LAST_STEP = 1'b1;

	// Mode codes; the unused code behaves as MODE_DIV
	localparam logic [1:0] MODE_DIV    = 2'd0;
	localparam logic [1:0] MODE_SHIFT  = 2'd1;
	localparam logic [1:0] MODE_DITHER = 2'd2;

	localparam logic [1:0] MODE_RST      = MODE_DIV;
	localparam logic [7:0] LAST_STEP_RST = 8'd15;

	// Step limit of the sixteen-step shift mode
	localparam logic [7:0] SHIFT_STEPS = 8'd16;

	localparam int LANES  = 3;   // red, green, blue
	localparam int CH_W   = 5;   // channel width incl. dither bit
	localparam int PROD_W = 13;  // channel magnitude times step
	localparam int QUO_W  = 5;   // quotient never exceeds channel magnitude

	// Dither increments by low-bit code; bit 0 red, bit 1 green, bit 2 blue
	localparam logic [LANES-1:0] DITHER_A [8] = '{
		3'b000, 3'b000, 3'b000, 3'b010, 3'b000, 3'b001, 3'b010, 3'b101
	};
	localparam logic [LANES-1:0] DITHER_B [8] = '{
		3'b000, 3'b100, 3'b010, 3'b100, 3'b001, 3'b100, 3'b001, 3'b010
	};

	typedef struct packed {
		logic [14:0] start_color;
		logic [14:0] end_color;
		logic [7:0]  step;
	} pgi_in_t;

	typedef struct packed {
		logic [11:0] color_a;
		logic [11:0] color_b;
	} pgi_out_t;

	// One color channel on its way through the divider
	typedef struct packed {
		logic [CH_W-1:0]   base;
		logic              neg;
		logic [PROD_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
	} pgi_lane_t;

	typedef struct packed {
		logic [1:0]                  mode;
		pgi_lane_t [LANES-1:0]       lane;
	} pgi_div_t;

	// Unscramble a nibble: nibble bit 3 is the channel LSB
	function automatic logic [3:0] unscramble(input logic [3:0] nib);
		return {nib[2:0], nib[3]};
	endfunction

	// Saturate a channel to 15 and scramble it back into a nibble
	function automatic logic [3:0] sat_scramble(input logic [CH_W-1:0] v);
		logic [3:0] u;
		u = (v > 5'd15) ? 4'hF : v[3:0];
		return {u[0], u[3:1]};
	endfunction

endpackage

>>> rtl/core/pgi_front.sv
// ----------------------------------------------------------------------------
// pgi_front
// Stages 1 and 2: unscramble the channels, form sign and magnitude of the
// channel difference, clamp the step, then multiply magnitude by step.
// ----------------------------------------------------------------------------
module pgi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  pgi_pkg::pgi_in_t  in_beat,
	input  logic [1:0]        mode,
	input  logic [7:0]        last_step,
	output logic              vld_s2,
	output pgi_pkg::pgi_div_t beat_s2
);
	import pgi_pkg::*;

	logic [LANES-1:0][CH_W-1:0] s_ch;
	logic [LANES-1:0][CH_W-1:0] e_ch;
	logic [LANES-1:0][CH_W-1:0] mag;
	logic [LANES-1:0]           neg;
	logic [7:0]                 k_clamp;

	logic                       vld_s1;
	logic [1:0]                 mode_s1;
	logic [LANES-1:0][CH_W-1:0] base_s1;
	logic [LANES-1:0][CH_W-1:0] mag_s1;
	logic [LANES-1:0]           neg_s1;
	logic [7:0]                 k_s1;

	logic [LANES-1:0][PROD_W-1:0] prod;
	pgi_div_t                     beat_d;

	// Unscramble, add dither bit in dither mode, take difference
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (mode == MODE_DITHER) begin
				s_ch[i] = {unscramble(in_beat.start_color[11-4*i -: 4]),
					in_beat.start_color[14-i]};
				e_ch[i] = {unscramble(in_beat.end_color[11-4*i -: 4]),
					in_beat.end_color[14-i]};
			end else begin
				s_ch[i] = {1'b0, unscramble(in_beat.start_color[11-4*i -: 4])};
				e_ch[i] = {1'b0, unscramble(in_beat.end_color[11-4*i -: 4])};
			end
			neg[i] = (e_ch[i] < s_ch[i]);
			mag[i] = neg[i] ? (s_ch[i] - e_ch[i]) : (e_ch[i] - s_ch[i]);
		end
	end

	// Clamp the step to the divisor, or to sixteen in shift mode
	always_comb begin
		if (mode == MODE_SHIFT) begin
			k_clamp = (in_beat.step > SHIFT_STEPS) ? SHIFT_STEPS : in_beat.step;
		end else begin
			k_clamp = (in_beat.step > last_step) ? last_step : in_beat.step;
		end
	end

	// Stage 1 and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		base_s1 <= s_ch;
		mag_s1  <= mag;
		neg_s1  <= neg;
		k_s1    <= k_clamp;
	end

	// Multiply; shift mode finishes here with a floor shift by four
	always_comb begin
		beat_d.mode = mode_s1;
		for (int i = 0; i < LANES; i++) begin
			prod[i] = PROD_W'(mag_s1[i]) * PROD_W'(k_s1);
			beat_d.lane[i].base = base_s1[i];
			beat_d.lane[i].neg  = neg_s1[i];
			if (mode_s1 == MODE_SHIFT) begin
				beat_d.lane[i].rem = '0;
				if (neg_s1[i]) begin
					beat_d.lane[i].quo = QUO_W'((prod[i] + PROD_W'(15)) >> 4);
				end else begin
					beat_d.lane[i].quo = QUO_W'(prod[i] >> 4);
				end
			end else begin
				beat_d.lane[i].rem = prod[i];
				beat_d.lane[i].quo = '0;
			end
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		beat_s2 <= beat_d;
	end

endmodule

>>> rtl/core/pgi_divider.sv
// ----------------------------------------------------------------------------
// pgi_divider
// Pipelined restoring division of the channel products by last_step, one
// quotient bit per stage, most significant first, three lanes side by side.
// ----------------------------------------------------------------------------
module pgi_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  pgi_pkg::pgi_div_t in_beat,
	input  logic [7:0]        last_step,
	output logic              out_vld,
	output pgi_pkg::pgi_div_t out_beat
);
	import pgi_pkg::*;

	logic     vld_s [QUO_W+1];
	pgi_div_t div_s [QUO_W+1];

	assign vld_s[0] = in_vld;
	assign div_s[0] = in_beat;

	for (genvar g = 0; g < QUO_W; g++) begin : g_step
		localparam int Sh = QUO_W - 1 - g;

		logic [PROD_W-1:0] dsh;
		pgi_div_t          nxt;

		assign dsh = PROD_W'({{(PROD_W-8){1'b0}}, last_step} << Sh);

		// Subtract the shifted divisor where it fits, set the quotient bit
		always_comb begin
			nxt = div_s[g];
			for (int i = 0; i < LANES; i++) begin
				if ((last_step != 8'd0) && (div_s[g].lane[i].rem >= dsh)) begin
					nxt.lane[i].rem     = div_s[g].lane[i].rem - dsh;
					nxt.lane[i].quo[Sh] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			div_s[g+1] <= nxt;
		end
	end

	assign out_vld  = vld_s[QUO_W];
	assign out_beat = div_s[QUO_W];

endmodule

>>> rtl/core/pgi_back.sv
// ----------------------------------------------------------------------------
// pgi_back
// Final stage: apply the signed quotient to the start channel, split into a
// dithered pair in dither mode, saturate, scramble and register the result.
// ----------------------------------------------------------------------------
module pgi_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  pgi_pkg::pgi_div_t  in_beat,
	output logic               done,
	output pgi_pkg::pgi_out_t  result
);
	import pgi_pkg::*;

	logic [LANES-1:0][CH_W-1:0] d_ch;
	logic [LANES-1:0][CH_W-1:0] a_ch;
	logic [LANES-1:0][CH_W-1:0] b_ch;
	logic [2:0]                 code;
	logic [LANES-1:0]           inc_a;
	logic [LANES-1:0]           inc_b;
	pgi_out_t                   res_d;

	// Rebuild the interpolated channel from sign and quotient
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (in_beat.lane[i].neg) begin
				d_ch[i] = in_beat.lane[i].base - in_beat.lane[i].quo;
			end else begin
				d_ch[i] = in_beat.lane[i].base + in_beat.lane[i].quo;
			end
		end
	end

	// Split into a dithered pair by the low bits of the three channels
	always_comb begin
		code  = {d_ch[0][0], d_ch[1][0], d_ch[2][0]};
		inc_a = DITHER_A[code];
		inc_b = DITHER_B[code];
		for (int i = 0; i < LANES; i++) begin
			if (in_beat.mode == MODE_DITHER) begin
				a_ch[i] = {1'b0, d_ch[i][CH_W-1:1]} + CH_W'(inc_a[i]);
				b_ch[i] = {1'b0, d_ch[i][CH_W-1:1]} + CH_W'(inc_b[i]);
			end else begin
				a_ch[i] = d_ch[i];
				b_ch[i] = d_ch[i];
			end
		end
		res_d.color_a = {sat_scramble(a_ch[0]), sat_scramble(a_ch[1]),
			sat_scramble(a_ch[2])};
		res_d.color_b = {sat_scramble(b_ch[0]), sat_scramble(b_ch[1]),
			sat_scramble(b_ch[2])};
	end

	// Output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_vld;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule

>>> rtl/core/palette_gradient_interpolator.sv
// ----------------------------------------------------------------------------
// palette_gradient_interpolator
// Interpolates between two scrambled-nibble palette colors by step number.
//
// Command channel: start with item (start_color, end_color, step) is taken at
// any rising edge where busy is low; busy never rises, so one beat can enter
// every cycle.
// Result channel: done strobes for one cycle with result (color_a, color_b).
// The receiver cannot stall; results must be taken as they appear.
// The result passes through one unpack stage, one multiply stage, five
// division stages (one quotient bit each) and one output stage.
// Throughput is one item per cycle.
// Configuration: cfg_we writes cfg_data into register cfg_idx (0 mode,
// 1 last_step) at the clock edge; write only while no items are in flight.
// Reset clears all valid bits, sets mode to 0 and last_step to 15.
// ----------------------------------------------------------------------------
module palette_gradient_interpolator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pgi_pkg::pgi_in_t  item,
	output logic              done,
	output pgi_pkg::pgi_out_t result,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_idx,
	input  logic [7:0]        cfg_data
);
	import pgi_pkg::*;

	logic       [1:0] mode_q;
	logic       [7:0] last_step_q;
	logic             vld_s2;
	pgi_div_t         beat_s2;
	logic             vld_div;
	pgi_div_t         beat_div;

	assign busy = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RST;
			last_step_q <= LAST_STEP_RST;
		end else if (cfg_we) begin
			if (cfg_idx == REG_MODE) begin
				mode_q <= cfg_data[1:0];
			end else begin
				last_step_q <= cfg_data;
			end
		end
	end

	pgi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start && !busy),
		.in_beat   (item),
		.mode      (mode_q),
		.last_step (last_step_q),
		.vld_s2    (vld_s2),
		.beat_s2   (beat_s2)
	);

	pgi_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s2),
		.in_beat   (beat_s2),
		.last_step (last_step_q),
		.out_vld   (vld_div),
		.out_beat  (beat_div)
	);

	pgi_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_div),
		.in_beat (beat_div),
		.done    (done),
		.result  (result)
	);

endmodule

>>> rtl/core/pgi_checker.sv
// ----------------------------------------------------------------------------
// pgi_checker
// Port-level checks of the interpolator: fixed latency in both directions,
// defined result data on every strobe, no configuration write right after an accepted beat.
// ----------------------------------------------------------------------------
module pgi_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              done,
	input  pgi_pkg::pgi_out_t result,
	input  logic              cfg_we
);
	import pgi_pkg::*;

	// Every accepted beat comes out as a result strobe
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##8 done)
		else $error("accepted beat produced no result after 8 cycles");

	// No result strobe without a matching accepted beat
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 8))
		else $error("result strobe without a matching accepted beat");

	// Result data is defined whenever it is strobed
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(result))
		else $error("result carries unknown bits");

	// No configuration write right after an accepted beat
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !cfg_we)
		else $error("configuration written right after an accepted beat");

endmodule

bind palette_gradient_interpolator pgi_checker u_pgi_checker (.*);

>>> bench/tb_palette_gradient_interpolator.sv
// ----------------------------------------------------------------------------
// tb_palette_gradient_interpolator
// Self-checking bench for the palette gradient interpolator. Each accepted
// command beat is run through an in-bench color blend model, and the expected
// color pair is queued. Each result strobe is checked against the oldest
// entry. A short directed set covers the divide, shift, dither and spare modes
// at their extremes. Random phases then sweep the register settings and the
// sender idle patterns.
// ----------------------------------------------------------------------------
module tb_palette_gradient_interpolator;
	import pgi_pkg::*;

	// Spare mode code; the block treats it as the divide mode
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int RAND_PHASES     = 16;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES   = 12;
	localparam int CYCLE_LIMIT     = 400000;

	// Tracks the register copy and the queue of color pairs still owed
	class gradient_scoreboard;
		logic [1:0] cur_mode      = MODE_RST;
		logic [7:0] cur_last_step = LAST_STEP_RST;
		pgi_out_t   expected_colors[$];
		int         errors        = 0;

		// Scrambled nibble to channel level: nibble bit 3 is the level LSB
		function int nib_level(logic [3:0] nib);
			return int'(nib[2:0]) * 2 + int'(nib[3]);
		endfunction

		// Clamp a level to 0..15 and fold it back into a scrambled nibble
		function logic [3:0] level_nib(int v);
			int u;
			u = (v < 0) ? 0 : (v > 15) ? 15 : v;
			return 4'((u / 2) + (u % 2) * 8);
		endfunction

		function pgi_out_t blend_color(pgi_in_t it);
			int         s, e, k, n, sh;
			int         ca[3];
			int         cb[3];
			logic [2:0] parity;
			pgi_out_t   res;

			n = int'(cur_last_step);
			for (int i = 0; i < 3; i++) begin
				sh = 8 - 4 * i;
				s  = nib_level(it.start_color[sh +: 4]);
				e  = nib_level(it.end_color[sh +: 4]);
				case (cur_mode)
					MODE_SHIFT: begin
						k     = (int'(it.step) > 16) ? 16 : int'(it.step);
						ca[i] = s + (((e - s) * k) >>> 4);
					end
					MODE_DITHER: begin
						// widen to five bits with the extra low bits 14..12
						s     = s * 2 + int'(it.start_color[14 - i]);
						e     = e * 2 + int'(it.end_color[14 - i]);
						k     = (int'(it.step) > n) ? n : int'(it.step);
						ca[i] = (n != 0) ? s + ((e - s) * k) / n : s;
					end
					default: begin
						k     = (int'(it.step) > n) ? n : int'(it.step);
						ca[i] = (n != 0) ? s + ((e - s) * k) / n : s;
					end
				endcase
			end

			if (cur_mode == MODE_DITHER) begin
				// split each channel; its dropped LSBs pick the bumps
				parity = 3'((ca[0] & 1) * 4 + (ca[1] & 1) * 2 + (ca[2] & 1));
				for (int i = 0; i < 3; i++) begin
					ca[i] = ca[i] / 2;
					cb[i] = ca[i];
				end
				case (parity)
					3'b001: cb[2] += 1;
					3'b010: cb[1] += 1;
					3'b011: begin ca[1] += 1; cb[2] += 1; end
					3'b100: cb[0] += 1;
					3'b101: begin ca[0] += 1; cb[2] += 1; end
					3'b110: begin cb[0] += 1; ca[1] += 1; end
					3'b111: begin ca[0] += 1; cb[1] += 1; ca[2] += 1; end
					default: ;
				endcase
			end else begin
				cb = ca;
			end

			res.color_a = {level_nib(ca[0]), level_nib(ca[1]), level_nib(ca[2])};
			res.color_b = {level_nib(cb[0]), level_nib(cb[1]), level_nib(cb[2])};
			return res;
		endfunction

		function void note_item(pgi_in_t it);
			expected_colors.push_back(blend_color(it));
		endfunction

		function void check_color(pgi_out_t got);
			pgi_out_t want;
			if (expected_colors.size() == 0) begin
				$error("unexpected result beat: color_a %h color_b %h",
					got.color_a, got.color_b);
				errors++;
				return;
			end
			want = expected_colors.pop_front();
			if (got.color_a !== want.color_a) begin
				$error("color_a: expected %h, got %h", want.color_a, got.color_a);
				errors++;
			end
			if (got.color_b !== want.color_b) begin
				$error("color_b: expected %h, got %h", want.color_b, got.color_b);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	pgi_in_t    item;
	logic       done;
	pgi_out_t   result;
	logic       cfg_we;
	logic [0:0] cfg_idx;
	logic [7:0] cfg_data;

	gradient_scoreboard sb;
	int                 cycle_count = 0;

	palette_gradient_interpolator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Record each command beat the block takes
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_item(item);
	end

	// Check each result beat as it strobes
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_color(result);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Present one command beat after a random idle run; return on the taking edge
	task automatic send_item(input pgi_in_t it, input int idle_pct);
		pgi_in_t junk;
		while ($urandom_range(99) < idle_pct) begin
			junk.start_color = 15'($urandom);
			junk.end_color   = 15'($urandom);
			junk.step        = 8'($urandom);
			start <= 1'b0;
			item  <= junk;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// Hold the sender until every owed result has come, then let the pipe settle
	task automatic drain();
		start <= 1'b0;
		while (sb.expected_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers; the mode write carries random upper data bits
	task automatic program_regs(input logic [1:0] mode_val, input logic [7:0] last_val);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_MODE;
		cfg_data <= {6'($urandom), mode_val};
		@(posedge clk);
		sb.cur_mode = mode_val;
		cfg_idx  <= REG_LAST_STEP;
		cfg_data <= last_val;
		@(posedge clk);
		sb.cur_last_step = last_val;
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [1:0] mode_pick;
		logic [7:0] last_pick;
		int         idle_pct;
		int         step_top;
		pgi_in_t    it;

		sb       = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		item     = '0;
		cfg_we   = 1'b0;
		cfg_idx  = REG_MODE;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: divide mode over fifteen steps
		send_item(pgi_in_t'{15'h0000, 15'h0000, 8'd0}, 0);
		send_item(pgi_in_t'{15'h0000, 15'h0FFF, 8'd15}, 0);
		send_item(pgi_in_t'{15'h0FFF, 15'h0000, 8'd7}, 0);
		send_item(pgi_in_t'{15'h7FFF, 15'h0000, 8'd255}, 0);
		send_item(pgi_in_t'{15'h1234, 15'h6ABC, 8'd8}, 0);
		drain();

		// Shift mode: full span, floor on falling ramps, step clamp at sixteen
		program_regs(MODE_SHIFT, 8'd15);
		send_item(pgi_in_t'{15'h0000, 15'h0FFF, 8'd16}, 0);
		send_item(pgi_in_t'{15'h0FFF, 15'h0000, 8'd1}, 0);
		send_item(pgi_in_t'{15'h0000, 15'h7FFF, 8'd255}, 0);
		send_item(pgi_in_t'{15'h0A5A, 15'h05A5, 8'd9}, 0);
		drain();

		// Dither mode: saturation on a full-scale bump, wide divisor
		program_regs(MODE_DITHER, 8'd255);
		send_item(pgi_in_t'{15'h7FFF, 15'h7FFF, 8'd0}, 0);
		send_item(pgi_in_t'{15'h0000, 15'h7FFF, 8'd255}, 0);
		send_item(pgi_in_t'{15'h0000, 15'h7FFF, 8'd128}, 0);
		send_item(pgi_in_t'{15'h1000, 15'h6ABC, 8'd77}, 0);
		drain();

		// Dither mode with a zero divisor splits the start color
		program_regs(MODE_DITHER, 8'd0);
		send_item(pgi_in_t'{15'h5A5A, 15'h0FFF, 8'd200}, 0);
		send_item(pgi_in_t'{15'h7FFF, 15'h0000, 8'd0}, 0);
		drain();

		// Spare mode acts as divide; one-step span
		program_regs(MODE_SPARE, 8'd1);
		send_item(pgi_in_t'{15'h0123, 15'h0FED, 8'd0}, 0);
		send_item(pgi_in_t'{15'h0123, 15'h0FED, 8'd1}, 0);
		send_item(pgi_in_t'{15'h7123, 15'h0FED, 8'd255}, 0);
		drain();

		// Divide mode at both divisor extremes
		program_regs(MODE_DIV, 8'd0);
		send_item(pgi_in_t'{15'h0ABC, 15'h0123, 8'd100}, 0);
		drain();
		program_regs(MODE_DIV, 8'd255);
		send_item(pgi_in_t'{15'h0000, 15'h0FFF, 8'd255}, 0);
		send_item(pgi_in_t'{15'h0FFF, 15'h0000, 8'd254}, 0);
		drain();

		// Random phases over modes, divisors and sender idle patterns
		for (int p = 0; p < RAND_PHASES; p++) begin
			mode_pick = 2'(p % 4);
			case (p % 6)
				0: last_pick = 8'd0;
				1: last_pick = 8'd1;
				2: last_pick = 8'd15;
				3: last_pick = 8'd16;
				4: last_pick = 8'd255;
				default: last_pick = 8'($urandom_range(2, 254));
			endcase
			case ((p / 2) % 4)
				1: idle_pct = 86;
				3: idle_pct = 31;
				default: idle_pct = 0;
			endcase
			program_regs(mode_pick, last_pick);
			step_top = (mode_pick == MODE_SHIFT) ? 17 : int'(last_pick) + 1;
			if (step_top > 255)
				step_top = 255;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				it.start_color = 15'($urandom);
				it.end_color   = 15'($urandom);
				// keep half the steps between zero and one past the clamp point
				it.step = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(step_top));
				send_item(it, idle_pct);
			end
			drain();
		end

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/pgi_pkg.sv
rtl/core/pgi_front.sv
rtl/core/pgi_divider.sv
rtl/core/pgi_back.sv
rtl/core/palette_gradient_interpolator.sv
rtl/core/pgi_checker.sv
bench/tb_palette_gradient_interpolator.sv
